[src/message_slot_sequence_reserver_core_assert.svh]
// Assertion macros for the message slot sequence reserver
`ifndef MESSAGE_SLOT_SEQUENCE_RESERVER_CORE_ASSERT_SVH
`define MESSAGE_SLOT_SEQUENCE_RESERVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MSR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSR_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSR_ASSERT(label, clk, rst, prop, msg)
`define MSR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[src/msr_pkg.sv]
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and constants of the message slot sequence reserver.
// ----------------------------------------------------------------------------
`default_nettype none
package msr_pkg;
  localparam int SeqBits  = 24;
  localparam int Slots    = 64;
  localparam int SlotBits = 6;
  localparam logic [SeqBits-1:0] HalfSpan = {1'b0, {(SeqBits-1){1'b1}}};

  typedef logic [SeqBits-1:0]  seq_t;
  typedef logic [SlotBits-1:0] slot_t;

  localparam logic [2:0] ActAcquire  = 3'd0;
  localparam logic [2:0] ActRollback = 3'd1;
  localparam logic [2:0] ActFindReq  = 3'd2;
  localparam logic [2:0] ActUpsert   = 3'd3;
  localparam logic [2:0] ActFindResp = 3'd4;
  localparam logic [2:0] ActRelReq   = 3'd5;
  localparam logic [2:0] ActRelResp  = 3'd6;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadCount = 3'd1;
  localparam logic [2:0] StNoSlot   = 3'd2;
  localparam logic [2:0] StConflict = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StMismatch = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic clr_scan;   // scan index to zero
    logic step_scan;  // advance scan index
    logic free_scan;  // scan for a free slot
    logic probe_hint; // look at hint, then next slot, then scan
    logic conflict;   // run conflict check at scan index
    logic commit;     // apply result and state update
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] action;
    logic       last;      // scan index at final slot
    logic       free_hit;  // free slot found
    logic       hit;       // lookup match found
    logic       fail;      // conflict seen
  } stat_t;
endpackage
`default_nettype wire

[src/msr_if.sv]
// ----------------------------------------------------------------------------
// msr_in_if / msr_out_if
// Valid-ready channels of the reserver.
// ----------------------------------------------------------------------------
`default_nettype none
interface msr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [23:0] msg_packets;
  logic [23:0] sequence_req;
  logic [5:0]  slot_id;
  modport source (output valid, action, msg_packets, sequence_req, slot_id, input ready);
  modport sink (input valid, action, msg_packets, sequence_req, slot_id, output ready);
endinterface

interface msr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  result_slot;
  logic [23:0] result_sequence;
  modport source (output valid, status, result_slot, result_sequence, input ready);
  modport sink (input valid, status, result_slot, result_sequence, output ready);
endinterface
`default_nettype wire

[src/msr_datapath.sv]
// ----------------------------------------------------------------------------
// msr_datapath
// Slot tables, scan index, compare logic and result formation.
// ----------------------------------------------------------------------------
`default_nettype none
module msr_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire msr_pkg::cmd_t  cmd,
  output msr_pkg::stat_t      stat,
  input  wire logic [2:0]     in_action,
  input  wire logic [23:0]    in_count,
  input  wire logic [23:0]    in_seq,
  input  wire logic [5:0]     in_slot,
  output logic [2:0]          res_status,
  output logic [5:0]          res_slot,
  output logic [23:0]         res_seq
);
  logic [msr_pkg::Slots-1:0] req_valid, req_reserved, resp_valid;
  msr_pkg::seq_t req_start [msr_pkg::Slots];
  msr_pkg::seq_t req_count [msr_pkg::Slots];
  msr_pkg::seq_t resp_start [msr_pkg::Slots];
  msr_pkg::seq_t resp_count [msr_pkg::Slots];
  msr_pkg::seq_t next_sequence;
  msr_pkg::slot_t next_slot, req_hint, resp_hint;

  logic [2:0]    action;
  msr_pkg::seq_t count, seqv, hoff;
  msr_pkg::slot_t sid, idx, fslot, hslot, p_idx;
  logic free_hit, hit, fail;
  logic [1:0] probe; // 0 hint, 1 next, 2 full scan
  logic p_probe, p_conf;
  msr_pkg::seq_t rd_req_start, rd_req_count, rd_resp_start, rd_resp_count;

  logic is_req, step, covered, live, cf, ok;
  msr_pkg::slot_t hint_sel, look, ra, cand;
  msr_pkg::seq_t lstart, lcount, cur;
  logic [2:0] st_n;
  msr_pkg::slot_t slot_n;
  msr_pkg::seq_t seq_n;

  assign is_req   = (action == msr_pkg::ActFindReq);
  assign cur      = next_sequence;
  assign cand     = next_slot + idx;
  assign hint_sel = is_req ? req_hint : resp_hint;
  always_comb begin
    case (probe)
      2'd0:    look = hint_sel;
      2'd1:    look = hint_sel + 6'd1;
      default: look = idx;
    endcase
  end
  assign ra = cmd.conflict ? idx : look;
  // hold the index while the hint and next slot are probed
  assign step = cmd.step_scan && !(cmd.probe_hint && probe != 2'd2);

  // judge the slot read in the previous cycle
  assign lstart  = is_req ? rd_req_start : rd_resp_start;
  assign lcount  = is_req ? rd_req_count : rd_resp_count;
  assign live    = is_req ? (req_valid[p_idx] && req_reserved[p_idx]) : resp_valid[p_idx];
  assign covered = p_probe && live && ((seqv - lstart) < lcount);
  assign cf = p_conf && (p_idx != fslot) && req_valid[p_idx] && req_reserved[p_idx] &&
              (((cur - rd_req_start) >= msr_pkg::HalfSpan) ||
               ((rd_req_start - cur) < count) || ((cur - rd_req_start) < rd_req_count));

  assign stat = '{action: action, last: (idx == 6'd63), free_hit: free_hit,
                  hit: hit, fail: fail};

  always_comb begin
    st_n = msr_pkg::StNotFound; slot_n = '0; seq_n = '0;
    case (action)
      msr_pkg::ActAcquire: begin
        if (count == '0 || count > msr_pkg::HalfSpan) st_n = msr_pkg::StBadCount;
        else if (!free_hit) st_n = msr_pkg::StNoSlot;
        else if (fail) st_n = msr_pkg::StConflict;
        else begin
          st_n = msr_pkg::StOk; slot_n = fslot; seq_n = cur;
        end
      end
      msr_pkg::ActRollback: begin
        if (count == '0) st_n = msr_pkg::StBadCount;
        else if (cur != seqv + count) st_n = msr_pkg::StMismatch;
        else begin
          st_n = msr_pkg::StOk; seq_n = seqv;
        end
      end
      msr_pkg::ActFindReq, msr_pkg::ActFindResp: begin
        if (hit) begin
          st_n = msr_pkg::StOk; slot_n = hslot; seq_n = hoff;
        end
      end
      msr_pkg::ActUpsert: begin
        if (count == '0) st_n = msr_pkg::StBadCount;
        else begin
          st_n = msr_pkg::StOk; slot_n = sid; seq_n = seqv;
        end
      end
      msr_pkg::ActRelReq, msr_pkg::ActRelResp: begin
        st_n = msr_pkg::StOk; slot_n = sid;
      end
      default: ;
    endcase
  end
  assign ok = (st_n == msr_pkg::StOk);

  // tables: one registered read a cycle, written on commit
  always_ff @(posedge clk) begin
    rd_req_start  <= req_start[ra];
    rd_req_count  <= req_count[ra];
    rd_resp_start <= resp_start[ra];
    rd_resp_count <= resp_count[ra];
    p_idx         <= ra;
    if (cmd.commit && ok && action == msr_pkg::ActAcquire) begin
      req_start[fslot] <= cur; req_count[fslot] <= count;
    end
    if (cmd.commit && ok && action == msr_pkg::ActUpsert) begin
      resp_start[sid] <= seqv; resp_count[sid] <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= in_action; count <= in_count; seqv <= in_seq; sid <= in_slot;
      free_hit <= 1'b0; hit <= 1'b0; fail <= 1'b0; probe <= 2'd0;
    end else begin
      if (cmd.free_scan && !free_hit && !req_valid[cand] && !req_reserved[cand]) begin
        free_hit <= 1'b1; fslot <= cand;
      end
      if (cmd.probe_hint && probe != 2'd2) probe <= probe + 2'd1;
      if (covered && !hit) begin
        hit <= 1'b1; hslot <= p_idx; hoff <= seqv - lstart;
      end
      if (cf) fail <= 1'b1;
    end
    if (cmd.clr_scan) idx <= '0;
    else if (step) idx <= idx + 6'd1;
    if (cmd.commit) begin
      res_status <= st_n; res_slot <= slot_n; res_seq <= seq_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= '0; req_reserved <= '0; resp_valid <= '0;
      next_sequence <= '0; next_slot <= '0; req_hint <= '0; resp_hint <= '0;
      p_probe <= 1'b0; p_conf <= 1'b0;
    end else begin
      p_probe <= cmd.probe_hint;
      p_conf  <= cmd.conflict;
      if (cmd.commit && ok) begin
        case (action)
          msr_pkg::ActAcquire: begin
            req_valid[fslot] <= 1'b1; req_reserved[fslot] <= 1'b1;
            next_sequence <= cur + count; next_slot <= fslot + 6'd1; req_hint <= fslot;
          end
          msr_pkg::ActRollback: next_sequence <= seqv;
          msr_pkg::ActFindReq: req_hint <= hslot;
          msr_pkg::ActFindResp: resp_hint <= hslot;
          msr_pkg::ActUpsert: begin resp_valid[sid] <= 1'b1; resp_hint <= sid; end
          msr_pkg::ActRelReq: begin req_valid[sid] <= 1'b0; req_reserved[sid] <= 1'b0; end
          msr_pkg::ActRelResp: resp_valid[sid] <= 1'b0;
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

[src/msr_ctrl.sv]
// ----------------------------------------------------------------------------
// msr_ctrl
// Sequencer: accept, scan slots, commit, present result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "message_slot_sequence_reserver_core_assert.svh"
module msr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output msr_pkg::cmd_t       cmd,
  input  wire msr_pkg::stat_t stat
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001, S_FREE = 7'b0000010, S_CONF = 7'b0000100,
    S_LOOK  = 7'b0001000, S_DRAIN = 7'b0010000, S_DONE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;
  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; cmd.clr_scan = 1'b1; state_next = S_FREE;
      end
      S_FREE: begin
        cmd.clr_scan = 1'b1;
        case (stat.action)
          msr_pkg::ActAcquire: state_next = S_CONF;
          msr_pkg::ActFindReq, msr_pkg::ActFindResp: state_next = S_LOOK;
          default: state_next = S_DONE;
        endcase
      end
      S_CONF: begin
        // free scan first pass, conflict check second pass
        cmd.step_scan = 1'b1;
        cmd.free_scan = 1'b1;
        if (stat.last) state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.step_scan = 1'b1;
        if (stat.action == msr_pkg::ActAcquire) cmd.conflict = 1'b1;
        else cmd.probe_hint = 1'b1;
        if (stat.last) state_next = S_DRAIN;
      end
      // let the last table read be judged
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin cmd.commit = 1'b1; state_next = S_OUT; end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `MSR_ASSERT(a_commit_out, clk, rst, cmd.commit |=> out_valid, "commit without result")
  `MSR_ASSERT(a_no_accept_busy, clk, rst, out_valid |-> !in_ready, "accept while result held")
  `MSR_ASSERT(a_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "result dropped")
endmodule
`default_nettype wire

[src/message_slot_sequence_reserver_core.sv]
// ----------------------------------------------------------------------------
// message_slot_sequence_reserver_core
// Request/response message slot tables with sequence reservation.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch (valid/ready); one result per item leaves on
// out_ch. One item is worked at a time. Each slot table has one registered
// read port, so a scan reads one slot per cycle and judges it in the next cycle.
// Acquire runs a free-slot pass and a conflict pass over all 64 slots.
// Find probes the hint and the next slot, then scans all 64 slots. Other
// actions run no scan. The block is ready for the next item in the cycle
// after the result leaves. The result holds on out_ch while the receiver
// stalls, and no item is taken until it leaves.
// Reset clears all valid bits, the next sequence, next slot and hints;
// the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module message_slot_sequence_reserver_core (
  input wire logic   clk,
  input wire logic   rst,
  msr_in_if.sink     in_ch,
  msr_out_if.source  out_ch
);
  msr_pkg::cmd_t  cmd;
  msr_pkg::stat_t stat;

  msr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .stat(stat)
  );

  msr_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_action(in_ch.action), .in_count(in_ch.msg_packets),
    .in_seq(in_ch.sequence_req), .in_slot(in_ch.slot_id),
    .res_status(out_ch.status), .res_slot(out_ch.result_slot),
    .res_seq(out_ch.result_sequence)
  );
endmodule
`default_nettype wire
